### rtl/core/bss_pkg.sv
// ----------------------------------------------------------------------------
// bss_pkg
// Shared widths, register map and word types of the byte substring search unit.
// ----------------------------------------------------------------------------
package bss_pkg;

  localparam int MAX_NEEDLE = 16;
  localparam int IDX_W      = $clog2(MAX_NEEDLE);
  localparam int LEN_W      = 5;
  localparam int CNT_W      = 21;
  localparam int ADDR_W     = 6;
  localparam int DATA_W     = 64;

  localparam logic [CNT_W-1:0] MAX_HAYSTACK = CNT_W'(1048576);

  localparam logic [2:0] REG_NEEDLE_LOW     = 3'd0;
  localparam logic [2:0] REG_NEEDLE_HIGH    = 3'd1;
  localparam logic [2:0] REG_NEEDLE_LENGTH  = 3'd2;
  localparam logic [2:0] REG_SEARCH_REVERSE = 3'd3;
  localparam logic [2:0] REG_START_GIVEN    = 3'd4;
  localparam logic [2:0] REG_START_INDEX    = 3'd5;

  typedef logic [MAX_NEEDLE-1:0][7:0] byte_row_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } byte_word_t;

  typedef struct packed {
    logic             found;
    logic [CNT_W-1:0] match_position;
  } result_word_t;

endpackage

### rtl/core/bss_match.sv
// ----------------------------------------------------------------------------
// bss_match
// Parallel compare of the newest window bytes against the needle.
// ----------------------------------------------------------------------------
module bss_match (
  input  bss_pkg::byte_row_t         window,
  input  bss_pkg::byte_row_t         needle,
  input  logic [bss_pkg::LEN_W-1:0]  needle_length,
  output logic                       hit
);
  import bss_pkg::*;

  logic [MAX_NEEDLE-1:0] used;
  logic [MAX_NEEDLE-1:0] same;
  logic                  len_ok;

  always_comb begin
    logic [LEN_W-1:0] sel;
    sel = '0;
    for (int k = 0; k < MAX_NEEDLE; k++) begin
      sel     = needle_length - LEN_W'(k) - LEN_W'(1);
      used[k] = LEN_W'(k) < needle_length;
      same[k] = window[k] == needle[sel[IDX_W-1:0]];
    end
  end

  assign len_ok = (needle_length != '0) && (needle_length <= LEN_W'(MAX_NEEDLE));
  assign hit    = len_ok && (&(same | ~used));

endmodule

### rtl/core/byte_substring_search_unit.sv
// ----------------------------------------------------------------------------
// byte_substring_search_unit
// Streaming exact search of a byte haystack for a needle of up to 16 bytes.
// ----------------------------------------------------------------------------
// Takes one haystack byte per clock. Every accepted byte is compared against
// the needle in the same cycle by a 16-byte parallel window compare, so the
// sustained rate is one byte per cycle. The result word appears in the cycle
// after the byte marked last is accepted and is held until taken; byte_stall
// rises only while a result waits under result_stall. Program the registers
// over APB (64-bit, byte address 8*index) between haystacks.
module byte_substring_search_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bss_pkg::ADDR_W-1:0]  paddr,
  input  logic [bss_pkg::DATA_W-1:0]  pwdata,
  output logic [bss_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  input  logic                        byte_valid,
  output logic                        byte_stall,
  input  bss_pkg::byte_word_t         byte_word,
  output logic                        result_valid,
  input  logic                        result_stall,
  output bss_pkg::result_word_t       result_word
);
  import bss_pkg::*;

  logic [63:0]       needle_low;
  logic [63:0]       needle_high;
  logic [LEN_W-1:0]  needle_length;
  logic              search_reverse;
  logic              start_given;
  logic [CNT_W-1:0]  start_index;

  byte_row_t         window;
  byte_row_t         window_next;
  byte_row_t         win_shift;
  byte_row_t         needle;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [CNT_W-1:0]  cnt_inc;
  logic              hit_seen;
  logic              hit_seen_next;
  logic [CNT_W-1:0]  hit_position;
  logic [CNT_W-1:0]  hit_position_next;
  logic [CNT_W-1:0]  pos;
  logic [CNT_W-1:0]  from;
  logic              cmp_hit;
  logic              take;
  logic              wr;
  logic [2:0]        reg_sel;

  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite && pready;
  assign reg_sel = paddr[ADDR_W-1:3];

  always_comb begin
    unique case (reg_sel)
      REG_NEEDLE_LOW:     prdata = needle_low;
      REG_NEEDLE_HIGH:    prdata = needle_high;
      REG_NEEDLE_LENGTH:  prdata = DATA_W'(needle_length);
      REG_SEARCH_REVERSE: prdata = DATA_W'(search_reverse);
      REG_START_GIVEN:    prdata = DATA_W'(start_given);
      REG_START_INDEX:    prdata = DATA_W'(start_index);
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      needle_low     <= '0;
      needle_high    <= '0;
      needle_length  <= '0;
      search_reverse <= 1'b0;
      start_given    <= 1'b0;
      start_index    <= '0;
    end else if (wr) begin
      unique case (reg_sel)
        REG_NEEDLE_LOW:     needle_low     <= pwdata;
        REG_NEEDLE_HIGH:    needle_high    <= pwdata;
        REG_NEEDLE_LENGTH:  needle_length  <= pwdata[LEN_W-1:0];
        REG_SEARCH_REVERSE: search_reverse <= pwdata[0];
        REG_START_GIVEN:    start_given    <= pwdata[0];
        REG_START_INDEX:    start_index    <= pwdata[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign needle     = {needle_high, needle_low};
  assign win_shift  = {window[MAX_NEEDLE-2:0], byte_word.data_byte};
  assign cnt_inc    = count + CNT_W'(1);
  assign pos        = cnt_inc - CNT_W'(needle_length) + CNT_W'(1);
  assign from       = (start_given && start_index > CNT_W'(1)) ? start_index : CNT_W'(1);
  assign byte_stall = result_valid && result_stall;
  assign take       = byte_valid && !byte_stall;

  bss_match u_match (
    .window        (win_shift),
    .needle        (needle),
    .needle_length (needle_length),
    .hit           (cmp_hit)
  );

  always_comb begin
    window_next       = window;
    count_next        = count;
    hit_seen_next     = hit_seen;
    hit_position_next = hit_position;
    if (count < MAX_HAYSTACK) begin
      window_next = win_shift;
      count_next  = cnt_inc;
      if (cmp_hit && cnt_inc >= CNT_W'(needle_length)) begin
        if (search_reverse) begin
          if (!(start_given && cnt_inc > start_index)) begin
            hit_seen_next     = 1'b1;
            hit_position_next = pos;
          end
        end else if (!hit_seen && pos >= from) begin
          hit_seen_next     = 1'b1;
          hit_position_next = pos;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window       <= '0;
      count        <= '0;
      hit_seen     <= 1'b0;
      hit_position <= '0;
    end else if (take) begin
      if (byte_word.last_byte) begin
        window       <= '0;
        count        <= '0;
        hit_seen     <= 1'b0;
        hit_position <= '0;
      end else begin
        window       <= window_next;
        count        <= count_next;
        hit_seen     <= hit_seen_next;
        hit_position <= hit_position_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (take && byte_word.last_byte) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && byte_word.last_byte) begin
      result_word.found          <= hit_seen_next;
      result_word.match_position <= hit_seen_next ? hit_position_next : '0;
    end
  end

  a_no_pos_when_missing: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_word.found |-> result_word.match_position == '0)
    else $error("match position set without a match");

  a_pos_nonzero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_word.found |-> result_word.match_position != '0)
    else $error("reported match at position zero");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    take && byte_word.last_byte |=> count == '0 && !hit_seen && result_valid)
    else $error("stream state not cleared after last byte");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= MAX_HAYSTACK)
    else $error("byte count past haystack limit");

  a_hit_in_range: assert property (@(posedge clk) disable iff (rst)
    hit_seen |-> hit_position != '0 && hit_position <= count)
    else $error("held match position outside counted bytes");

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the byte substring search unit.
// ----------------------------------------------------------------------------
// Programs the needle, direction and start bound over APB, streams haystacks
// one byte word at a time and predicts the found flag and match position of
// each haystack from a behavioral copy of the search. Covers forward and
// reverse searches, start bounds, empty and oversized needles, a needle change
// in the middle of a haystack and result back-pressure. Random traffic runs
// under three idling patterns.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bss_pkg::*;

  localparam int HAY_LIMIT = 1048576;

  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              psel         = 1'b0;
  logic              penable      = 1'b0;
  logic              pwrite       = 1'b0;
  logic [ADDR_W-1:0] paddr        = '0;
  logic [DATA_W-1:0] pwdata       = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              byte_valid   = 1'b0;
  logic              byte_stall;
  byte_word_t        byte_word    = '0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  result_word_t      result_word;

  byte_substring_search_unit uut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .byte_word    (byte_word),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_word  (result_word)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

  // Register copies
  logic [63:0] cfg_low   = '0;
  logic [63:0] cfg_high  = '0;
  logic [4:0]  cfg_len   = '0;
  logic        cfg_rev   = 1'b0;
  logic        cfg_given = 1'b0;
  logic [20:0] cfg_start = '0;

  // Search state
  logic [7:0]   hay_window [MAX_NEEDLE] = '{default: '0};
  int unsigned  hay_count = 0;
  bit           hit_seen  = 1'b0;
  int unsigned  hit_pos   = 0;
  result_word_t pending_answers [$];

  int errors        = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_request  = 0;
  int hold_left     = 0;

  task automatic predict_search_byte(input logic [7:0] b, input logic lst);
    int unsigned  len;
    int unsigned  pos;
    int unsigned  from;
    logic [127:0] needle;
    bit           same;
    result_word_t ans;
    len    = cfg_len;
    needle = {cfg_high, cfg_low};
    if (hay_count < HAY_LIMIT) begin
      for (int i = MAX_NEEDLE - 1; i > 0; i--) hay_window[i] = hay_window[i-1];
      hay_window[0] = b;
      hay_count++;
      if (len != 0 && len <= MAX_NEEDLE && hay_count >= len) begin
        same = 1'b1;
        for (int i = 0; i < len; i++)
          if (hay_window[len-1-i] != needle[8*i +: 8]) same = 1'b0;
        if (same) begin
          pos = hay_count - len + 1;
          if (cfg_rev) begin
            if (!(cfg_given && hay_count > cfg_start)) begin
              hit_seen = 1'b1;
              hit_pos  = pos;
            end
          end else begin
            from = (cfg_given && cfg_start > 1) ? cfg_start : 1;
            if (!hit_seen && pos >= from) begin
              hit_seen = 1'b1;
              hit_pos  = pos;
            end
          end
        end
      end
    end
    if (lst) begin
      ans.found          = hit_seen;
      ans.match_position = hit_seen ? CNT_W'(hit_pos) : '0;
      pending_answers.insert(pending_answers.size(), ans);
      foreach (hay_window[i]) hay_window[i] = '0;
      hay_count = 0;
      hit_seen  = 1'b0;
      hit_pos   = 0;
    end
  endtask

  always @(posedge clk) begin
    result_word_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_answers.size() == 0) begin
        if (errors < 10)
          $display("unexpected result: found=%0d pos=%0d",
                   result_word.found, result_word.match_position);
        errors++;
      end else begin
        want = pending_answers.pop_front();
        if (result_word.found !== want.found ||
            result_word.match_position !== want.match_position) begin
          if (errors < 10)
            $display("mismatch: expected found=%0d pos=%0d, got found=%0d pos=%0d",
                     want.found, want.match_position,
                     result_word.found, result_word.match_position);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else
      result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  task automatic send_byte(input logic [7:0] b, input logic lst);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_word  <= '{data_byte: b, last_byte: lst};
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    predict_search_byte(b, lst);
  endtask

  task automatic send_haystack(input logic [7:0] hay [$]);
    foreach (hay[i]) send_byte(hay[i], i == hay.size() - 1);
  endtask

  // drop valid, then hold until every result has been taken
  task automatic wait_quiet();
    byte_valid <= 1'b0;
    @(posedge clk);
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 3'b000});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_NEEDLE_LOW:     cfg_low   = value;
      REG_NEEDLE_HIGH:    cfg_high  = value;
      REG_NEEDLE_LENGTH:  cfg_len   = value[4:0];
      REG_SEARCH_REVERSE: cfg_rev   = value[0];
      REG_START_GIVEN:    cfg_given = value[0];
      REG_START_INDEX:    cfg_start = value[20:0];
      default: ;
    endcase
  endtask

  task automatic program_search(input logic [63:0] lo, hi, input logic [4:0] len,
                                input logic rev, given, input logic [20:0] start);
    wait_quiet();
    write_reg(REG_NEEDLE_LOW, lo);
    write_reg(REG_NEEDLE_HIGH, hi);
    write_reg(REG_NEEDLE_LENGTH, 64'(len));
    write_reg(REG_SEARCH_REVERSE, 64'(rev));
    write_reg(REG_START_GIVEN, 64'(given));
    write_reg(REG_START_INDEX, 64'(start));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_forward_search();
    program_search(64'h00FF, '1, 5'd2, 1'b0, 1'b0, 21'd0);
    send_haystack('{8'hFF, 8'h00, 8'hFF, 8'h00});
    program_search(64'h00FF, '1, 5'd2, 1'b0, 1'b1, 21'd2);
    send_haystack('{8'hFF, 8'h00, 8'hFF, 8'h00});
    program_search(64'h00FF, '1, 5'd2, 1'b0, 1'b1, 21'd0);
    send_haystack('{8'hFF, 8'h00});
    program_search(64'h00FF, '1, 5'd2, 1'b0, 1'b1, 21'd9);
    send_haystack('{8'hFF, 8'h00});
  endtask

  task automatic test_reverse_search();
    program_search(64'h00FF, '0, 5'd2, 1'b1, 1'b0, 21'd0);
    send_haystack('{8'hFF, 8'h00, 8'hFF, 8'h00});
    program_search(64'h00FF, '0, 5'd2, 1'b1, 1'b1, 21'd3);
    send_haystack('{8'hFF, 8'h00, 8'hFF, 8'h00});
    program_search(64'h00FF, '0, 5'd2, 1'b1, 1'b1, 21'd0);
    send_haystack('{8'hFF, 8'h00});
    program_search(64'h00FF, '0, 5'd2, 1'b1, 1'b1, 21'd50);
    send_haystack('{8'hFF, 8'h00});
  endtask

  task automatic test_needle_corners();
    program_search(64'hFF, '0, 5'd0, 1'b0, 1'b0, 21'd0);
    send_haystack('{8'hFF});
    program_search('0, '0, 5'd31, 1'b0, 1'b0, 21'd0);
    send_haystack('{8'h00, 8'h00});
    program_search(64'h00_00FF, '0, 5'd3, 1'b0, 1'b0, 21'd0);
    send_haystack('{8'hFF, 8'h00});
  endtask

  task automatic test_change_mid_haystack();
    program_search(64'h11, '0, 5'd1, 1'b0, 1'b0, 21'd0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    program_search(64'h00, '0, 5'd1, 1'b0, 1'b0, 21'd0);
    send_haystack('{8'hFF, 8'h00});
  endtask

  task automatic test_result_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    program_search(64'h5A, '0, 5'd1, 1'b0, 1'b0, 21'd0);
    hold_request = 300;
    repeat (60) begin
      if ($urandom_range(0, 1)) send_byte(8'h5A, 1'b0);
      send_byte(8'($urandom), 1'b1);
    end
    wait_quiet();
    repeat (20) send_byte($urandom_range(0, 1) ? 8'h5A : 8'h00, 1'b1);
  endtask

  task automatic test_random_traffic(input int snd_pct, rcv_pct, item_goal);
    logic [7:0]   alpha [4];
    logic [7:0]   hay [$];
    logic [127:0] needle;
    logic [4:0]   len;
    logic [20:0]  start;
    int           sent;
    int           hay_len;
    int           piece;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    sent = 0;
    while (sent < item_goal) begin
      foreach (alpha[i]) alpha[i] = 8'($urandom);
      for (int i = 0; i < 16; i++) needle[8*i +: 8] = alpha[$urandom_range(0, 3)];
      case ($urandom_range(0, 19))
        0: len = 5'd0;
        1: len = 5'($urandom_range(17, 31));
        default: len = 5'($urandom_range(1, 16));
      endcase
      case ($urandom_range(0, 9))
        0: start = 21'($urandom);
        1: start = 21'(HAY_LIMIT);
        default: start = 21'($urandom_range(0, 30));
      endcase
      program_search(needle[63:0], needle[127:64], len, 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), start);
      repeat ($urandom_range(3, 8)) begin
        hay_len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 48)
                                              : $urandom_range(1, 24);
        hay.delete();
        while (hay.size() < hay_len) begin
          if ($urandom_range(0, 4) == 0) begin
            piece = (len >= 1 && len <= 16) ? len : 4;
            if ($urandom_range(0, 3) == 0) piece = $urandom_range(1, piece);
            for (int i = 0; i < piece; i++) hay.insert(hay.size(), needle[8*i +: 8]);
          end else if ($urandom_range(0, 9) == 0)
            hay.insert(hay.size(), 8'($urandom));
          else
            hay.insert(hay.size(), alpha[$urandom_range(0, 3)]);
        end
        send_haystack(hay);
        sent += hay.size();
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_forward_search();
    test_reverse_search();
    test_needle_corners();
    test_change_mid_haystack();
    test_result_backpressure();
    test_random_traffic(26, 60, 550);
    test_random_traffic(60, 26, 550);
    test_random_traffic(0, 0, 550);
    wait_quiet();
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

endmodule
